// ===== sv/cre_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cre_pkg
// Shared types and constants for the CIGAR run expander.
// ----------------------------------------------------------------------------
package cre_pkg;

    localparam int MAX_OPS_DEF = 1024;

    localparam int CH_W     = 8;
    localparam int INDEX_W  = 10;
    localparam int COUNT_W  = 11;
    localparam int LIMIT_W  = 11;
    localparam int CFG_IDX_W = 1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OP_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE  = 1'd1;

    localparam logic [LIMIT_W-1:0] OP_LIMIT_RESET = 11'd1024;

    // item kinds
    localparam logic KIND_CHAR = 1'b0;
    localparam logic KIND_READ = 1'b1;

    localparam logic [CH_W-1:0] CH_ZERO = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE = 8'h39;

    typedef struct packed {
        logic               kind;
        logic               first;
        logic [CH_W-1:0]    ch;
        logic [INDEX_W-1:0] index;
    } in_t;

    typedef struct packed {
        logic [CH_W-1:0]    op_char;
        logic [COUNT_W-1:0] count;
        logic               error;
    } out_t;

endpackage

// ===== sv/cre_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cre_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module cre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/cigar_run_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cigar_run_expander
// Expands CIGAR text into a store of single op characters and reads it back.
// ----------------------------------------------------------------------------
// One item is in work at a time. A digit, a read, a refused letter or a letter
// with no run passes through the steps accept, execute (count update or store
// read issue) and result load; the result load waits until the output register
// is free. A letter with run length N writes N copies in between, since the op
// store has one write port and takes one copy per cycle. The next word is
// accepted in the cycle after the previous result has moved into the output
// register, even if the sink has not yet taken it. The store is not cleared
// after reset: only entries below the filled count are ever returned.
// ----------------------------------------------------------------------------
module cigar_run_expander
    import cre_pkg::*;
#(
    parameter int MAX_OPS = MAX_OPS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_t                  s_data,

    output logic                 m_valid,
    input  logic                 m_ready,
    output out_t                 m_data,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LIMIT_W-1:0]   cfg_data
);

    // store address, count/run width, compare width, digit product width
    localparam int AW = $clog2(MAX_OPS);
    localparam int CW = $clog2(MAX_OPS + 1);
    localparam int SW = ((CW > LIMIT_W) ? CW : LIMIT_W) + 1;
    localparam int PW = CW + 4;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_EXEC   = 2'd1;
    localparam logic [1:0] ST_FILL   = 2'd2;
    localparam logic [1:0] ST_RESULT = 2'd3;

    logic [1:0]         state_reg,   state_next;
    logic [CW-1:0]      filled_reg,  filled_next;
    logic [CW-1:0]      run_reg,     run_next;
    logic               ovf_reg,     ovf_next;
    logic [LIMIT_W-1:0] limit_reg,   limit_next;
    logic               reverse_reg, reverse_next;
    logic               kind_reg,    kind_next;
    logic [CH_W-1:0]    ch_reg,      ch_next;
    logic [INDEX_W-1:0] index_reg,   index_next;
    logic               hit_reg,     hit_next;
    logic               m_valid_reg, m_valid_next;
    out_t               out_reg,     out_next;

    logic               s_fire;
    logic               is_digit;
    logic [PW-1:0]      run_x10;
    logic [SW-1:0]      lim_eff;
    logic [SW-1:0]      fill_sum;
    logic [SW-1:0]      read_pos;
    logic               slot_free;

    logic               ram_we;
    logic               ram_re;
    logic [CH_W-1:0]    ram_rdata;

    assign s_ready   = (state_reg == ST_IDLE);
    assign s_fire    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign slot_free = !m_valid_reg || m_ready;

    assign is_digit = (ch_reg >= CH_ZERO) && (ch_reg <= CH_NINE);

    // run * 10 + digit
    assign run_x10 = {run_reg, 3'b000} + {1'b0, run_reg, 1'b0}
                   + PW'(ch_reg - CH_ZERO);

    // effective limit is min(op_limit, MAX_OPS)
    assign lim_eff  = (SW'(limit_reg) > SW'(MAX_OPS)) ? SW'(MAX_OPS) : SW'(limit_reg);
    assign fill_sum = SW'(filled_reg) + SW'(run_reg);
    assign read_pos = reverse_reg ? (SW'(filled_reg) - SW'(1) - SW'(index_reg))
                                  : SW'(index_reg);

    assign ram_we = (state_reg == ST_FILL);
    assign ram_re = (state_reg == ST_EXEC) && (kind_reg == KIND_READ);

    cre_ram #(
        .WIDTH (CH_W),
        .DEPTH (MAX_OPS)
    ) u_op_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (filled_reg[AW-1:0]),
        .wdata (ch_reg),
        .re    (ram_re),
        .raddr (read_pos[AW-1:0]),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        filled_next  = filled_reg;
        run_next     = run_reg;
        ovf_next     = ovf_reg;
        limit_next   = limit_reg;
        reverse_next = reverse_reg;
        kind_next    = kind_reg;
        ch_next      = ch_reg;
        index_next   = index_reg;
        hit_next     = hit_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;

        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_OP_LIMIT: limit_next   = cfg_data;
                CFG_REVERSE:  reverse_next = cfg_data[0];
                default: ;
            endcase
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    kind_next  = s_data.kind;
                    ch_next    = s_data.ch;
                    index_next = s_data.index;
                    // new string: clear before the character is taken
                    if (s_data.kind == KIND_CHAR && s_data.first) begin
                        filled_next = '0;
                        run_next    = '0;
                        ovf_next    = 1'b0;
                    end
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = ST_RESULT;
                hit_next   = (SW'(index_reg) < SW'(filled_reg));
                if (kind_reg == KIND_CHAR && !ovf_reg) begin
                    if (is_digit) begin
                        if (run_x10 > PW'(MAX_OPS)) begin
                            run_next = CW'(MAX_OPS);
                        end else begin
                            run_next = run_x10[CW-1:0];
                        end
                    end else if (fill_sum >= lim_eff) begin
                        ovf_next = 1'b1;
                    end else if (run_reg != '0) begin
                        state_next = ST_FILL;
                    end
                end
            end
            ST_FILL: begin
                // one copy per cycle; run counts down to its cleared value
                filled_next = filled_reg + CW'(1);
                run_next    = run_reg - CW'(1);
                if (run_reg == CW'(1)) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (slot_free) begin
                    out_next.op_char = (kind_reg == KIND_READ && hit_reg) ? ram_rdata
                                                                          : '0;
                    out_next.count   = COUNT_W'(filled_reg);
                    out_next.error   = ovf_reg;
                    m_valid_next     = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            filled_reg  <= '0;
            run_reg     <= '0;
            ovf_reg     <= 1'b0;
            limit_reg   <= OP_LIMIT_RESET;
            reverse_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            filled_reg  <= filled_next;
            run_reg     <= run_next;
            ovf_reg     <= ovf_next;
            limit_reg   <= limit_next;
            reverse_reg <= reverse_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // item and result payload
    always_ff @(posedge aclk) begin
        kind_reg  <= kind_next;
        ch_reg    <= ch_next;
        index_reg <= index_next;
        hit_reg   <= hit_next;
        out_reg   <= out_next;
    end

endmodule
